### sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master register access package
// Shared codes, phase encoding and payload types of the I2C register master.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

   // Request opcodes.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Position of the transfer within its byte sequence.
   localparam logic [2:0] STEP_ADDR = 3'd0;
   localparam logic [2:0] STEP_REG  = 3'd1;
   localparam logic [2:0] STEP_DATA = 3'd2;
   localparam logic [2:0] STEP_RX   = 3'd3;
   localparam logic [2:0] STEP_END  = 3'd4;

   // Bus phase sequencer, one-hot.
   typedef enum logic [12:0] {
      PH_IDLE     = 13'b0000000000001,
      PH_START_A  = 13'b0000000000010,
      PH_START_B  = 13'b0000000000100,
      PH_START_C  = 13'b0000000001000,
      PH_TX_SETUP = 13'b0000000010000,
      PH_TX_HIGH  = 13'b0000000100000,
      PH_TX_HOLD  = 13'b0000001000000,
      PH_RX_SETUP = 13'b0000010000000,
      PH_RX_HIGH  = 13'b0000100000000,
      PH_RX_HOLD  = 13'b0001000000000,
      PH_STOP_A   = 13'b0010000000000,
      PH_STOP_B   = 13'b0100000000000,
      PH_STOP_C   = 13'b1000000000000
   } phase_type;

   // One request: a bus phase tick with an optional command.
   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] reg_address;
      logic [7:0] write_data;
      logic       sda_in;
   } req_type;

   // One result: line levels and status of that tick.
   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       retry_pulse;
   } rsp_type;

endpackage

`default_nettype wire

### sv/i2cm_if.sv
// ----------------------------------------------------------------------------
// I2C master register access channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] reg_address;
   logic [7:0] write_data;
   logic       sda_in;

   modport source (output valid, opcode, reg_address, write_data, sda_in, input ready);
   modport sink   (input valid, opcode, reg_address, write_data, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;
   logic       retry_pulse;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data,
                   retry_pulse, input ready);
   modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_data,
                   retry_pulse, output ready);
endinterface

interface i2cm_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### sv/i2c_master_register_access.sv
// ----------------------------------------------------------------------------
// I2C master register access
// Single-byte register write and read master driven by bus phase ticks.
// ----------------------------------------------------------------------------
// Usage:
// Each request on req is one bus phase tick and carries the sampled SDA level.
// While the master is idle, a request with opcode write or read starts a
// transfer; its register and data bytes are latched on that request. Each
// request gives exactly one response on rsp with the SCL/SDA levels to drive
// for that tick plus busy, done, retry and the last byte read.
// The target's write address byte is written on csr while the master is idle;
// the restarted read phase of a read uses that address plus one.
// The response is registered and appears in the cycle after its request is
// accepted. Throughput is one request per cycle while the receiver takes each
// response.
// Reset clears the sequencer to idle and empties the response register.
// When the receiver stalls, the response holds and req.ready drops until it is
// taken; a new request is accepted in the same cycle the response leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_register_access
   import i2cm_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   i2cm_req_if.sink   req,
   i2cm_rsp_if.source rsp,
   i2cm_csr_if.sink   csr
);

   logic       accept;
   logic [7:0] device_address_ff;
   req_type    req_data;
   rsp_type    step_rsp;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff;

   // Configuration register, to be written only while idle; the block does not enforce it.
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= 8'd0;
      end else if (csr.valid) begin
         device_address_ff <= csr.data;
      end
   end

   // A request is taken whenever the response register is free or draining.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      req_data.opcode      = req.opcode;
      req_data.reg_address = req.reg_address;
      req_data.write_data  = req.write_data;
      req_data.sda_in      = req.sda_in;
   end

   i2cm_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (accept),
      .req_data       (req_data),
      .device_address (device_address_ff),
      .rsp_data       (step_rsp)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.scl_out     = rsp_data_ff.scl_out;
   assign rsp.sda_out     = rsp_data_ff.sda_out;
   assign rsp.busy_res    = rsp_data_ff.busy_res;
   assign rsp.done_res    = rsp_data_ff.done_res;
   assign rsp.read_data   = rsp_data_ff.read_data;
   assign rsp.retry_pulse = rsp_data_ff.retry_pulse;

endmodule

`default_nettype wire

### sv/i2cm_core.sv
// ----------------------------------------------------------------------------
// I2C master register access sequencer
// Bus phase state machine that advances by at most one phase per stepped request.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_core
   import i2cm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire req_type    req_data,
   input  wire logic [7:0] device_address,
   output rsp_type         rsp_data
);

   phase_type  phase_ff, phase_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_byte_ff, shift_byte_in;
   logic [2:0] byte_step_ff, byte_step_in;
   logic       is_read_ff, is_read_in;
   logic [7:0] latched_reg_ff, latched_reg_in;
   logic [7:0] latched_data_ff, latched_data_in;
   logic [7:0] received_byte_ff, received_byte_in;
   logic       ack_seen_ff, ack_seen_in;

   logic       scl;
   logic       sda;
   logic       done;
   logic       retry;
   logic       tx_bit;

   // Bit on the line while sending: the MSB first, then the released ACK slot.
   assign tx_bit = bit_count_ff[3] ? 1'b1 : shift_byte_ff[~bit_count_ff[2:0]];

   // Next state and line levels of this tick.
   always_comb begin
      phase_in         = phase_ff;
      bit_count_in     = bit_count_ff;
      shift_byte_in    = shift_byte_ff;
      byte_step_in     = byte_step_ff;
      is_read_in       = is_read_ff;
      latched_reg_in   = latched_reg_ff;
      latched_data_in  = latched_data_ff;
      received_byte_in = received_byte_ff;
      ack_seen_in      = ack_seen_ff;
      scl              = 1'b1;
      sda              = 1'b1;
      done             = 1'b0;
      retry            = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            if (req_data.opcode == OP_WRITE || req_data.opcode == OP_READ) begin
               is_read_in      = (req_data.opcode == OP_READ);
               latched_reg_in  = req_data.reg_address;
               latched_data_in = req_data.write_data;
               byte_step_in    = STEP_ADDR;
               bit_count_in    = 4'd0;
               phase_in        = PH_START_A;
            end
         end
         PH_START_A: begin
            // Wait with lines released until the bus is seen free.
            if (req_data.sda_in) begin
               phase_in = PH_START_B;
            end
         end
         PH_START_B: begin
            sda      = 1'b0;
            phase_in = PH_START_C;
         end
         PH_START_C: begin
            scl           = 1'b0;
            sda           = 1'b0;
            shift_byte_in = (byte_step_ff == STEP_ADDR) ? device_address
                                                        : device_address + 8'd1;
            bit_count_in  = 4'd0;
            phase_in      = PH_TX_SETUP;
         end
         PH_TX_SETUP: begin
            scl      = 1'b0;
            sda      = tx_bit;
            phase_in = PH_TX_HIGH;
         end
         PH_TX_HIGH: begin
            sda = tx_bit;
            if (bit_count_ff[3]) begin
               ack_seen_in = req_data.sda_in;
            end
            phase_in = PH_TX_HOLD;
         end
         PH_TX_HOLD: begin
            scl = 1'b0;
            sda = tx_bit;
            if (!bit_count_ff[3]) begin
               bit_count_in = bit_count_ff + 4'd1;
               phase_in     = PH_TX_SETUP;
            end else begin
               // Byte and its acknowledge are done: pick the next bus action.
               case (byte_step_ff)
                  STEP_ADDR: begin
                     if (ack_seen_ff) begin
                        retry    = 1'b1;
                        phase_in = PH_STOP_A;
                     end else begin
                        byte_step_in  = STEP_REG;
                        shift_byte_in = latched_reg_ff;
                        bit_count_in  = 4'd0;
                        phase_in      = PH_TX_SETUP;
                     end
                  end
                  STEP_REG: begin
                     byte_step_in = STEP_DATA;
                     if (is_read_ff) begin
                        phase_in = PH_STOP_A;
                     end else begin
                        shift_byte_in = latched_data_ff;
                        bit_count_in  = 4'd0;
                        phase_in      = PH_TX_SETUP;
                     end
                  end
                  STEP_DATA: begin
                     byte_step_in = STEP_RX;
                     if (is_read_ff) begin
                        shift_byte_in = 8'd0;
                        bit_count_in  = 4'd0;
                        phase_in      = PH_RX_SETUP;
                     end else begin
                        phase_in = PH_STOP_A;
                     end
                  end
                  default: begin
                     phase_in = PH_STOP_A;
                  end
               endcase
            end
         end
         PH_RX_SETUP: begin
            scl      = 1'b0;
            phase_in = PH_RX_HIGH;
         end
         PH_RX_HIGH: begin
            if (!bit_count_ff[3]) begin
               shift_byte_in = {shift_byte_ff[6:0], req_data.sda_in};
            end
            phase_in = PH_RX_HOLD;
         end
         PH_RX_HOLD: begin
            scl = 1'b0;
            if (!bit_count_ff[3]) begin
               bit_count_in = bit_count_ff + 4'd1;
               phase_in     = PH_RX_SETUP;
            end else begin
               received_byte_in = shift_byte_ff;
               byte_step_in     = STEP_END;
               phase_in         = PH_STOP_A;
            end
         end
         PH_STOP_A: begin
            scl      = 1'b0;
            sda      = 1'b0;
            phase_in = PH_STOP_B;
         end
         PH_STOP_B: begin
            sda      = 1'b0;
            phase_in = PH_STOP_C;
         end
         PH_STOP_C: begin
            // A retry and the turnaround of a read both restart the bus.
            if (byte_step_ff == STEP_ADDR || (is_read_ff && byte_step_ff == STEP_DATA)) begin
               phase_in = PH_START_A;
            end else begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Sequencer state advances once per accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         bit_count_ff     <= 4'd0;
         shift_byte_ff    <= 8'd0;
         byte_step_ff     <= STEP_ADDR;
         is_read_ff       <= 1'b0;
         latched_reg_ff   <= 8'd0;
         latched_data_ff  <= 8'd0;
         received_byte_ff <= 8'd0;
         ack_seen_ff      <= 1'b1;
      end else if (step) begin
         phase_ff         <= phase_in;
         bit_count_ff     <= bit_count_in;
         shift_byte_ff    <= shift_byte_in;
         byte_step_ff     <= byte_step_in;
         is_read_ff       <= is_read_in;
         latched_reg_ff   <= latched_reg_in;
         latched_data_ff  <= latched_data_in;
         received_byte_ff <= received_byte_in;
         ack_seen_ff      <= ack_seen_in;
      end
   end

   // Result of this tick.
   always_comb begin
      rsp_data.scl_out     = scl;
      rsp_data.sda_out     = sda;
      rsp_data.busy_res    = (phase_in != PH_IDLE);
      rsp_data.done_res    = done;
      rsp_data.read_data   = received_byte_in;
      rsp_data.retry_pulse = retry;
   end

endmodule

`default_nettype wire

### sv/i2cm_checker.sv
// ----------------------------------------------------------------------------
// I2C master register access checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       scl_out,
   input wire logic       sda_out,
   input wire logic       busy_res,
   input wire logic       done_res,
   input wire logic [7:0] read_data,
   input wire logic       retry_pulse
);

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(scl_out) && $stable(sda_out)
         && $stable(busy_res) && $stable(done_res) && $stable(read_data)
         && $stable(retry_pulse))
   else $error("stalled response changed");

   // The final STOP leaves the master idle with both lines released.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> !busy_res && scl_out && sda_out && !retry_pulse)
   else $error("done response not idle with released lines");

   // A retry comes on the low-clock tick of a released address acknowledge.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && retry_pulse |-> busy_res && !scl_out && sda_out && !done_res)
   else $error("retry response with wrong line levels");

   // Reset empties the response register.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
   else $error("response valid right after reset");

endmodule

bind i2c_master_register_access i2cm_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .scl_out     (rsp.scl_out),
   .sda_out     (rsp.sda_out),
   .busy_res    (rsp.busy_res),
   .done_res    (rsp.done_res),
   .read_data   (rsp.read_data),
   .retry_pulse (rsp.retry_pulse)
);

`default_nettype wire

### dv/tb_i2c_master_register_access.sv
// ----------------------------------------------------------------------------
// I2C master register access testbench
// Drives bus phase ticks into the master and checks every response against
// a tick-accurate model of the START, byte, ACK, receive and STOP sequencing.
// Covers register writes and reads, address NACK retries, a busy bus at
// START, commands sent mid-transfer, and device address wrap. Traffic runs
// under several mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module tb_i2c_master_register_access;
   import i2cm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Opcode with no command behind it; the master treats it as a plain tick.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RSP_LATENCY = 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_PRINTED = 100;

   logic clock = 1'b0;
   logic reset;

   i2cm_req_if req_ch ();
   i2cm_rsp_if rsp_ch ();
   i2cm_csr_if csr_ch ();

   i2c_master_register_access dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the master's sequencer and the target address register.
   phase_type  ph       = PH_IDLE;
   logic [3:0] bit_cnt  = '0;
   logic [7:0] shift_q  = '0;
   logic [2:0] step     = STEP_ADDR;
   logic       is_rd    = 1'b0;
   logic [7:0] reg_q    = '0;
   logic [7:0] data_q   = '0;
   logic [7:0] rx_byte  = '0;
   logic       ack_q    = 1'b1;
   logic [7:0] dev_addr = '0;

   rsp_type expected_rsp_q[$];

   // Stimulus knobs.
   int idle_pct  = 0;
   int stall_pct = 0;
   int nack_pct  = 0;
   int busy_pct  = 0;
   int cmd_pct   = 0;
   int nack_left = 0;
   int busy_left = 0;
   int rx_level  = -1;

   // Counters for the run summary and the verdict.
   int err_count   = 0;
   int n_req       = 0;
   int n_rsp       = 0;
   int n_writes    = 0;
   int n_reads     = 0;
   int n_retries   = 0;
   int n_done      = 0;
   int n_cfg       = 0;
   int cycle_count = 0;

   // Load a byte into the transmit shifter and begin its first bit.
   function automatic void load_tx(logic [7:0] value);
      shift_q = value;
      bit_cnt = 4'd0;
      ph      = PH_TX_SETUP;
   endfunction

   // Advance the sequencer model by one tick and return the line levels.
   function automatic rsp_type predict_tick(req_type r);
      rsp_type o;
      logic    retry;
      logic    done;
      o     = '0;
      o.scl_out = 1'b1;
      o.sda_out = 1'b1;
      retry = 1'b0;
      done  = 1'b0;
      case (ph)
         PH_IDLE: begin
            if (r.opcode == OP_WRITE || r.opcode == OP_READ) begin
               is_rd   = (r.opcode == OP_READ);
               reg_q   = r.reg_address;
               data_q  = r.write_data;
               step    = STEP_ADDR;
               bit_cnt = 4'd0;
               ph      = PH_START_A;
               if (is_rd) n_reads++;
               else n_writes++;
            end
         end
         // A low SDA here means another master holds the bus, so wait.
         PH_START_A: if (r.sda_in) ph = PH_START_B;
         PH_START_B: begin
            o.sda_out = 1'b0;
            ph = PH_START_C;
         end
         PH_START_C: begin
            o.scl_out = 1'b0;
            o.sda_out = 1'b0;
            load_tx(step == STEP_ADDR ? dev_addr : 8'(dev_addr + 8'd1));
         end
         PH_TX_SETUP, PH_TX_HIGH, PH_TX_HOLD: begin
            o.sda_out = (bit_cnt < 4'd8) ? shift_q[7 - bit_cnt] : 1'b1;
            o.scl_out = (ph == PH_TX_HIGH);
            if (ph == PH_TX_SETUP) begin
               ph = PH_TX_HIGH;
            end else if (ph == PH_TX_HIGH) begin
               if (bit_cnt >= 4'd8) ack_q = r.sda_in;
               ph = PH_TX_HOLD;
            end else if (bit_cnt < 4'd8) begin
               bit_cnt++;
               ph = PH_TX_SETUP;
            end else begin
               // Byte and its ACK slot are done; pick what follows.
               case (step)
                  STEP_ADDR: begin
                     if (ack_q) begin
                        retry = 1'b1;
                        ph    = PH_STOP_A;
                     end else begin
                        step = STEP_REG;
                        load_tx(reg_q);
                     end
                  end
                  STEP_REG: begin
                     step = STEP_DATA;
                     if (is_rd) ph = PH_STOP_A;
                     else load_tx(data_q);
                  end
                  STEP_DATA: begin
                     step = STEP_RX;
                     if (is_rd) begin
                        shift_q = '0;
                        bit_cnt = 4'd0;
                        ph      = PH_RX_SETUP;
                     end else begin
                        ph = PH_STOP_A;
                     end
                  end
                  default: ph = PH_STOP_A;
               endcase
            end
         end
         PH_RX_SETUP, PH_RX_HIGH, PH_RX_HOLD: begin
            o.scl_out = (ph == PH_RX_HIGH);
            if (ph == PH_RX_SETUP) begin
               ph = PH_RX_HIGH;
            end else if (ph == PH_RX_HIGH) begin
               if (bit_cnt < 4'd8) shift_q = {shift_q[6:0], r.sda_in};
               ph = PH_RX_HOLD;
            end else if (bit_cnt < 4'd8) begin
               bit_cnt++;
               ph = PH_RX_SETUP;
            end else begin
               rx_byte = shift_q;
               step    = STEP_END;
               ph      = PH_STOP_A;
            end
         end
         PH_STOP_A: begin
            o.scl_out = 1'b0;
            o.sda_out = 1'b0;
            ph = PH_STOP_B;
         end
         PH_STOP_B: begin
            o.sda_out = 1'b0;
            ph = PH_STOP_C;
         end
         PH_STOP_C: begin
            // A retry or the turnaround of a read starts again.
            if (step == STEP_ADDR || (is_rd && step == STEP_DATA)) begin
               ph = PH_START_A;
            end else begin
               ph   = PH_IDLE;
               done = 1'b1;
            end
         end
         default: ph = PH_IDLE;
      endcase
      o.busy_res    = (ph != PH_IDLE);
      o.done_res    = done;
      o.read_data   = rx_byte;
      o.retry_pulse = retry;
      return o;
   endfunction

   // Choose the SDA level of the next tick from where the master will be.
   function automatic logic pick_sda();
      if (ph == PH_START_A) begin
         if (busy_left > 0) begin
            busy_left--;
            return 1'b0;
         end
         return $urandom_range(0, 99) >= busy_pct;
      end
      if (ph == PH_TX_HIGH && bit_cnt == 4'd8 && step == STEP_ADDR) begin
         if (nack_left > 0) begin
            nack_left--;
            return 1'b1;
         end
         return $urandom_range(0, 99) < nack_pct;
      end
      if (rx_level >= 0 && ph == PH_RX_HIGH) return rx_level[0];
      return 1'($urandom);
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      err_count++;
      if (err_count <= MAX_PRINTED)
         $display("ERROR response %0d: %s is %0h, expected %0h", n_rsp, what, got, want);
   endtask

   // Check each response, track register writes and predict each request.
   always @(posedge clock) begin : monitor
      rsp_type want;
      req_type r;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected response, read_data", rsp_ch.read_data, 8'h00);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_ch.scl_out !== want.scl_out)
                  report_mismatch("scl_out", 8'(rsp_ch.scl_out), 8'(want.scl_out));
               if (rsp_ch.sda_out !== want.sda_out)
                  report_mismatch("sda_out", 8'(rsp_ch.sda_out), 8'(want.sda_out));
               if (rsp_ch.busy_res !== want.busy_res)
                  report_mismatch("busy_res", 8'(rsp_ch.busy_res), 8'(want.busy_res));
               if (rsp_ch.done_res !== want.done_res)
                  report_mismatch("done_res", 8'(rsp_ch.done_res), 8'(want.done_res));
               if (rsp_ch.read_data !== want.read_data)
                  report_mismatch("read_data", rsp_ch.read_data, want.read_data);
               if (rsp_ch.retry_pulse !== want.retry_pulse)
                  report_mismatch("retry_pulse", 8'(rsp_ch.retry_pulse),
                                  8'(want.retry_pulse));
            end
            n_rsp++;
         end
         if (csr_ch.valid && csr_ch.ready) begin
            dev_addr = csr_ch.data;
            n_cfg++;
         end
         if (req_ch.valid && req_ch.ready) begin
            r.opcode      = req_ch.opcode;
            r.reg_address = req_ch.reg_address;
            r.write_data  = req_ch.write_data;
            r.sda_in      = req_ch.sda_in;
            want = predict_tick(r);
            if (want.retry_pulse) n_retries++;
            if (want.done_res) n_done++;
            expected_rsp_q.push_back(want);
            n_req++;
         end
      end
   end

   // Receiver back-pressure.
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_rsp_q.size());
         $display("FAIL i2c_master_register_access");
         $finish;
      end
   end

   // Send one request, with random gaps first; returns on a falling edge.
   task automatic send_req(logic [1:0] op, logic [7:0] ra, logic [7:0] wd, logic sda);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.opcode      = op;
      req_ch.reg_address = ra;
      req_ch.write_data  = wd;
      req_ch.sda_in      = sda;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Stop sending and wait until every response has come back.
   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(logic [7:0] value);
      wait_drained();
      csr_ch.valid = 1'b1;
      csr_ch.data  = value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Issue one command and keep ticking until the master is idle again.
   task automatic run_transfer(logic [1:0] op, logic [7:0] ra, logic [7:0] wd);
      send_req(op, ra, wd, 1'($urandom));
      while (ph != PH_IDLE) begin
         if ($urandom_range(0, 99) < cmd_pct)
            send_req(2'($urandom), 8'($urandom), 8'($urandom), pick_sda());
         else
            send_req(OP_TICK, 8'($urandom), 8'($urandom), pick_sda());
      end
   endtask

   // Idle ticks, including the unused opcode, leave both lines released.
   task automatic test_idle_ticks();
      csr_write(8'h00);
      send_req(OP_TICK, 8'h00, 8'h00, 1'b0);
      send_req(OP_UNUSED, 8'hFF, 8'hFF, 1'b1);
      send_req(OP_TICK, 8'hFF, 8'h00, 1'b1);
      send_req(OP_UNUSED, 8'h00, 8'hFF, 1'b0);
   endtask

   task automatic test_register_write();
      csr_write(8'hA6);
      run_transfer(OP_WRITE, 8'h00, 8'hFF);
   endtask

   // A read with the address at its top value, so the read address wraps.
   task automatic test_register_read();
      csr_write(8'hFF);
      rx_level = 1;
      run_transfer(OP_READ, 8'h00, 8'hFF);
      rx_level = -1;
   endtask

   // A NACK on the first address byte forces STOP and a fresh START.
   task automatic test_address_nack();
      csr_write(8'h3C);
      nack_left = 1;
      run_transfer(OP_READ, 8'h42, 8'h24);
   endtask

   // The master holds off while the bus reads low at START.
   task automatic test_bus_busy();
      busy_left = 2;
      run_transfer(OP_WRITE, 8'hC3, 8'h3C);
   endtask

   // Commands that arrive mid-transfer are ignored.
   task automatic test_command_while_busy();
      cmd_pct = 100;
      run_transfer(OP_READ, 8'h99, 8'h66);
      cmd_pct = 0;
   endtask

   // Mostly well-formed transfers with random content, plus noise.
   task automatic test_random_traffic(int idle, int stall, int budget);
      int start;
      idle_pct  = idle;
      stall_pct = stall;
      start     = n_req;
      while (n_req - start < budget) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0:       csr_write(8'h00);
               1:       csr_write(8'hFF);
               default: csr_write(8'($urandom));
            endcase
         end
         if ($urandom_range(0, 99) < 80) begin
            nack_pct = 8;
            busy_pct = 8;
            cmd_pct  = 4;
            run_transfer($urandom_range(0, 1) ? OP_READ : OP_WRITE,
                         8'($urandom), 8'($urandom));
         end else if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 6))
               send_req($urandom_range(0, 1) ? OP_TICK : OP_UNUSED,
                        8'($urandom), 8'($urandom), 1'($urandom));
         end else begin
            // Broken sequences: frequent NACKs and a busy bus.
            nack_pct = 50;
            busy_pct = 50;
            cmd_pct  = 30;
            run_transfer($urandom_range(0, 1) ? OP_READ : OP_WRITE,
                         8'($urandom), 8'($urandom));
         end
      end
      wait_drained();
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_TICK;
      req_ch.reg_address = '0;
      req_ch.write_data  = '0;
      req_ch.sda_in      = 1'b1;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.data        = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_ticks();
      test_register_write();
      test_register_read();
      test_address_nack();
      test_bus_busy();
      test_command_while_busy();
      test_random_traffic(0, 0, 50);
      test_random_traffic(60, 0, 50);
      test_random_traffic(0, 60, 50);
      test_random_traffic(18, 18, 50);

      wait_drained();
      repeat (RSP_LATENCY + 4) @(posedge clock);

      $display("Run covered %0d ticks: %0d register writes, %0d register reads, %0d completed.",
               n_req, n_writes, n_reads, n_done);
      $display("It saw %0d address NACK retries across %0d target address settings.",
               n_retries, n_cfg);
      if (err_count == 0) begin
         $display("PASS i2c_master_register_access");
      end else begin
         $display("FAIL i2c_master_register_access");
      end
      $finish;
   end

endmodule
